// ----- rtl/qte_pkg.sv -----
// qte_pkg: shared constants, types and helpers of the quaternion to euler block
// used by qte_cordic and quaternion_to_euler_angles
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qte_pkg;

	// cordic arctangent table, atan(2^-i) with 2^32 = 2pi
	localparam int ATAN_LEN = 24;
	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// datapath width of the cordic operands
	localparam int CW = 36;

	// square root result bits (root of a value up to 2^60)
	localparam int SQRT_BITS = 31;

	localparam logic [14:0] THRESH_RESET = 15'd16381;
	localparam logic signed [15:0] ANG_NORTH = 16'sh4000;
	localparam logic signed [15:0] ANG_SOUTH = -16'sh4000;

	typedef enum logic [1:0] {
		POLE_NONE  = 2'd0,
		POLE_NORTH = 2'd1,
		POLE_SOUTH = 2'd2
	} pole_t;

	// 32 bit binary angle to 16 bits, round half up with wrap
	function automatic logic [15:0] round16(input logic [31:0] a);
		logic [31:0] r;
		r = a + 32'h0000_8000;
		return r[31:16];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/qte_cordic.sv -----
// qte_cordic: pipelined vectoring cordic, atan2(y, x) as a 32 bit binary angle
// one prep stage and one register stage per iteration; uses qte_pkg
`timescale 1ns / 1ps
`default_nettype none

module qte_cordic import qte_pkg::*; #(
	parameter int STAGES = 16,
	parameter int W = 36
) (
	input  wire                 clk,
	input  wire                 en,
	input  wire signed [W-1:0]  y_in,
	input  wire signed [W-1:0]  x_in,
	output logic [31:0]         angle
);

	logic signed [W-1:0] x_s [STAGES+1];
	logic signed [W-1:0] y_s [STAGES+1];
	logic [31:0]         a_s [STAGES+1];
	logic                z_s [STAGES+1];

	// prep: fold left half plane onto the right, note the all zero case
	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in[W-1]) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				a_s[0] <= 32'h8000_0000;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				a_s[0] <= 32'd0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i+1] <= z_s[i];
				if (!y_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - ATAN_TAB[i];
				end
			end
		end
	end

	assign angle = z_s[STAGES] ? 32'd0 : a_s[STAGES];

endmodule

`default_nettype wire

// ----- rtl/quaternion_to_euler_angles.sv -----
// quaternion_to_euler_angles: throughput one quaternion per cycle unless the output stalls;
// the depth is set by the 31 stage square root
// followed by the attitude cordic, heading and bank run in parallel and wait in delay lines
// a stall freezes the whole pipeline; in_ready is low only while a result waits
// reset (arst_n low, asynchronous) clears all valid bits and loads the threshold 16381
// depends on qte_pkg and qte_cordic
`timescale 1ns / 1ps
`default_nettype none

module quaternion_to_euler_angles import qte_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	// configuration write channel
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [14:0]         pole_threshold,
	// quaternion input channel
	input  wire                in_valid,
	output logic               in_ready,
	input  wire signed [15:0]  qx,
	input  wire signed [15:0]  qy,
	input  wire signed [15:0]  qz,
	input  wire signed [15:0]  qw,
	// euler angle output channel
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [15:0] attitude,
	output logic signed [15:0] heading,
	output logic signed [15:0] bank,
	output logic [1:0]         pole
);

	// stage indexes of the valid chain
	localparam int IDX_HC = CORDIC_STAGES + 2;    // heading/bank cordic result
	localparam int DLY    = SQRT_BITS + 2;        // wait of heading/bank for attitude
	localparam int LAT    = CORDIC_STAGES + SQRT_BITS + 6;

	logic       en;
	logic [14:0] pole_threshold_q;
	logic       vld_s [LAT];
	pole_t      pole_s [LAT-2];

	// one enable for every stage: move when the output slot is free or taken
	assign en        = !vld_s[LAT-1] || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_threshold_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			pole_threshold_q <= pole_threshold;
		end
	end

	// valid bits ride along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < LAT; j++) vld_s[j] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int j = 1; j < LAT; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	// ---- stage 1: all the component products, exact q2.30
	logic signed [31:0] xy_s1, zw_s1, yw_s1, xz_s1, xw_s1, yz_s1;
	logic signed [31:0] xx_s1, yy_s1, zz_s1;
	logic signed [15:0] x_s1, w_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			xy_s1 <= qx * qy;
			zw_s1 <= qz * qw;
			yw_s1 <= qy * qw;
			xz_s1 <= qx * qz;
			xw_s1 <= qx * qw;
			yz_s1 <= qy * qz;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			x_s1  <= qx;
			w_s1  <= qw;
		end
	end

	// ---- stage 2: singularity test, pole decision, saturated 2t, atan2 operands
	logic signed [32:0] t_c, thr_c;
	logic signed [33:0] hy_c, hx_c, by_c, bx_c;
	logic signed [31:0] s_c;
	logic               north_c, south_c;
	pole_t              pole_c;

	assign t_c     = 33'(xy_s1) + 33'(zw_s1);
	assign thr_c   = $signed({3'b000, pole_threshold_q, 15'd0});
	assign north_c = t_c > thr_c;
	assign south_c = t_c < -thr_c;

	always_comb begin
		// 2t saturated to +-1 in q2.30
		if (t_c > 33'sd536870912) begin
			s_c = 32'sd1073741824;
		end else if (t_c < -33'sd536870912) begin
			s_c = -32'sd1073741824;
		end else begin
			s_c = 32'(t_c <<< 1);
		end
		priority if (north_c) begin
			pole_c = POLE_NORTH;
		end else if (south_c) begin
			pole_c = POLE_SOUTH;
		end else begin
			pole_c = POLE_NONE;
		end
		// heading: atan2(2(yw - xz), 1 - 2(yy + zz)), or atan2(x, w) at a pole
		if (north_c || south_c) begin
			hy_c = 34'(x_s1);
			hx_c = 34'(w_s1);
		end else begin
			hy_c = (34'(yw_s1) - 34'(xz_s1)) <<< 1;
			hx_c = 34'sd1073741824 - ((34'(yy_s1) + 34'(zz_s1)) <<< 1);
		end
		// bank: atan2(2(xw - yz), 1 - 2(xx + zz))
		by_c = (34'(xw_s1) - 34'(yz_s1)) <<< 1;
		bx_c = 34'sd1073741824 - ((34'(xx_s1) + 34'(zz_s1)) <<< 1);
	end

	logic signed [CW-1:0] hy_s2, hx_s2, by_s2, bx_s2;
	logic signed [31:0]   s_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			hy_s2 <= CW'(hy_c);
			hx_s2 <= CW'(hx_c);
			by_s2 <= CW'(by_c);
			bx_s2 <= CW'(bx_c);
			s_s2  <= s_c;
		end
	end

	// pole code travels with the item from stage 2 to the output
	always_ff @(posedge clk) begin
		if (en) begin
			pole_s[0] <= pole_c;
			for (int j = 1; j < LAT-2; j++) pole_s[j] <= pole_s[j-1];
		end
	end

	// ---- stage 3: s^2 as three partial products of its 15 bit upper and 16 bit lower halves
	logic [30:0] sabs_c;
	logic [29:0] aa_s3;
	logic [30:0] ab_s3;
	logic [31:0] bb_s3;
	logic signed [31:0] s_s3;

	assign sabs_c = s_s2[31] ? 31'(-s_s2) : s_s2[30:0];

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s3 <= sabs_c[30:16] * sabs_c[30:16];
			ab_s3 <= sabs_c[30:16] * sabs_c[15:0];
			bb_s3 <= sabs_c[15:0] * sabs_c[15:0];
			s_s3  <= s_s2;
		end
	end

	// ---- stage 4: radicand 2^60 - s^2
	logic [61:0] sq_c;
	logic [60:0] v_s4;
	logic signed [31:0] s_s4;

	assign sq_c = ({aa_s3, 32'd0}) + ({14'd0, ab_s3, 17'd0}) + ({30'd0, bb_s3});

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4 <= 61'(62'h1000_0000_0000_0000 - sq_c);
			s_s4 <= s_s3;
		end
	end

	// ---- square root: one result bit per stage, msb first
	logic [62:0]          rem_s  [SQRT_BITS+1];
	logic [SQRT_BITS-1:0] root_s [SQRT_BITS+1];
	logic signed [31:0]   sv_s   [SQRT_BITS+1];

	assign rem_s[0]  = {2'b00, v_s4};
	assign root_s[0] = '0;
	assign sv_s[0]   = s_s4;

	for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
		localparam int K = SQRT_BITS - 1 - j;
		logic [62:0] trial;
		assign trial = (63'(root_s[j]) << (K + 1)) + (63'd1 << (2 * K));
		always_ff @(posedge clk) begin
			if (en) begin
				sv_s[j+1] <= sv_s[j];
				if (rem_s[j] >= trial) begin
					rem_s[j+1]  <= rem_s[j] - trial;
					root_s[j+1] <= root_s[j] | (SQRT_BITS'(1) << K);
				end else begin
					rem_s[j+1]  <= rem_s[j];
					root_s[j+1] <= root_s[j];
				end
			end
		end
	end

	// ---- cordic units
	logic [31:0] att_ang, head_ang, bank_ang;

	qte_cordic #(.STAGES(CORDIC_STAGES), .W(CW)) u_att (
		.clk   (clk),
		.en    (en),
		.y_in  (CW'(sv_s[SQRT_BITS])),
		.x_in  ($signed({{(CW-SQRT_BITS){1'b0}}, root_s[SQRT_BITS]})),
		.angle (att_ang)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES), .W(CW)) u_head (
		.clk   (clk),
		.en    (en),
		.y_in  (hy_s2),
		.x_in  (hx_s2),
		.angle (head_ang)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES), .W(CW)) u_bank (
		.clk   (clk),
		.en    (en),
		.y_in  (by_s2),
		.x_in  (bx_s2),
		.angle (bank_ang)
	);

	// heading and bank finished early: round now, then wait for attitude
	logic [31:0] h2_c;
	logic [15:0] head_fin_c, bank_fin_c;
	pole_t       pole_hb;

	assign pole_hb = pole_s[IDX_HC-1];

	always_comb begin
		h2_c = {head_ang[30:0], 1'b0};
		if (pole_hb == POLE_SOUTH) h2_c = 32'd0 - h2_c;
		if (pole_hb == POLE_NONE) begin
			head_fin_c = round16(head_ang);
			bank_fin_c = round16(bank_ang);
		end else begin
			head_fin_c = round16(h2_c);
			bank_fin_c = 16'd0;
		end
	end

	logic [15:0] hdly_s [DLY];
	logic [15:0] bdly_s [DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			hdly_s[0] <= head_fin_c;
			bdly_s[0] <= bank_fin_c;
			for (int j = 1; j < DLY; j++) begin
				hdly_s[j] <= hdly_s[j-1];
				bdly_s[j] <= bdly_s[j-1];
			end
		end
	end

	// ---- output register
	pole_t pole_fin;
	assign pole_fin = pole_s[LAT-3];

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (pole_fin)
				POLE_NORTH: attitude <= ANG_NORTH;
				POLE_SOUTH: attitude <= ANG_SOUTH;
				default:    attitude <= $signed(round16(att_ang));
			endcase
			heading <= $signed(hdly_s[DLY-1]);
			bank    <= $signed(bdly_s[DLY-1]);
			pole    <= pole_fin;
		end
	end

	assign out_valid = vld_s[LAT-1];

`ifndef NO_ASSERTIONS
	// at a pole the bank angle is forced to zero
	a_pole_bank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pole != POLE_NONE) |-> bank == 16'sd0)
		else $error("bank not zero at a pole");

	// north pole attitude is +pi/2
	a_north_att: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pole == POLE_NORTH) |-> attitude == ANG_NORTH)
		else $error("north pole attitude wrong");

	// south pole attitude is -pi/2
	a_south_att: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pole == POLE_SOUTH) |-> attitude == ANG_SOUTH)
		else $error("south pole attitude wrong");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// tb: self-checking bench for quaternion_to_euler_angles
// predicts euler angles with an in-bench cordic model and compares every output transfer
// depends on qte_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb;
	import qte_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 37;
	localparam int N_RANDOM = 1600;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint ONE_Q30 = 64'sd1 << 30;

	typedef struct packed {
		logic signed [15:0] att;
		logic signed [15:0] head;
		logic signed [15:0] bnk;
		pole_t              pl;
	} euler_t;

	// scoreboard: holds predicted angles in order and checks output transfers
	class euler_scoreboard;
		euler_t pending[$];
		int errors;
		logic [14:0] thresh;

		function new();
			errors = 0;
			thresh = THRESH_RESET;
		endfunction

		// vectoring cordic, 32 bit angle with 2^32 = 2pi
		function automatic logic [31:0] vec_atan2(longint y, longint x);
			logic [31:0] ang;
			longint xs, ys;
			ang = 0;
			if (x == 0 && y == 0)
				return 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				ang = 32'h8000_0000;
			end
			for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					ang = ang + ATAN_TAB[i];
				end else begin
					x = x - ys;
					y = y + xs;
					ang = ang - ATAN_TAB[i];
				end
			end
			return ang;
		endfunction

		// floor square root by bit pairs
		function automatic longint floor_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function automatic logic [15:0] to_bam16(logic [31:0] a);
			logic [31:0] r;
			r = a + 32'h8000;
			return r[31:16];
		endfunction

		function automatic euler_t predict_angles(logic signed [15:0] qx, qy, qz, qw);
			euler_t e;
			longint x, y, z, w, t, thr, s, c;
			logic [31:0] h;
			x = qx;
			y = qy;
			z = qz;
			w = qw;
			t = x * y + z * w;
			thr = longint'(thresh) << 15;
			if (t > thr || t < -thr) begin
				h = vec_atan2(x, w) * 2;
				if (t > thr) begin
					e.att = ANG_NORTH;
					e.pl = POLE_NORTH;
				end else begin
					h = 32'd0 - h;
					e.att = ANG_SOUTH;
					e.pl = POLE_SOUTH;
				end
				e.head = to_bam16(h);
				e.bnk = 16'sd0;
			end else begin
				s = 2 * t;
				if (s > ONE_Q30)
					s = ONE_Q30;
				if (s < -ONE_Q30)
					s = -ONE_Q30;
				c = floor_sqrt(longint'(ONE_Q30 * ONE_Q30 - s * s));
				e.att = to_bam16(vec_atan2(s, c));
				e.head = to_bam16(vec_atan2(2 * (y * w - x * z),
					ONE_Q30 - 2 * (y * y + z * z)));
				e.bnk = to_bam16(vec_atan2(2 * (x * w - y * z),
					ONE_Q30 - 2 * (x * x + z * z)));
				e.pl = POLE_NONE;
			end
			return e;
		endfunction

		function void note_quaternion(logic signed [15:0] qx, qy, qz, qw);
			pending.push_back(predict_angles(qx, qy, qz, qw));
		endfunction

		task report(string what, int got, int exp_val);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $realtime);
			errors++;
		endtask

		task check_angles(euler_t got);
			euler_t e;
			if (pending.size() == 0) begin
				$display("unexpected output transfer at %0t", $realtime);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.att !== e.att)
				report("attitude", got.att, e.att);
			if (got.head !== e.head)
				report("heading", got.head, e.head);
			if (got.bnk !== e.bnk)
				report("bank", got.bnk, e.bnk);
			if (got.pl !== e.pl)
				report("pole", got.pl, e.pl);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [14:0] pole_threshold = THRESH_RESET;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] qx = 0, qy = 0, qz = 0, qw = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] attitude, heading, bank;
	logic [1:0] pole;

	euler_scoreboard sb;
	longint cycles = 0;
	// long receiver hold-off so the pipeline fills and backs up into in_ready
	int hold_left = 0;
	bit sink_quiet = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pole_threshold(pole_threshold),
		.in_valid(in_valid), .in_ready(in_ready),
		.qx(qx), .qy(qy), .qz(qz), .qw(qw),
		.out_valid(out_valid), .out_ready(out_ready),
		.attitude(attitude), .heading(heading), .bank(bank), .pole(pole)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// output side: check each transfer, then draw the next stall
	initial begin
		int gap;
		sb = new();
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_angles('{attitude, heading, bank, pole_t'(pole)});
			if (hold_left > 0) begin
				out_ready <= 0;
				hold_left--;
			end else if (out_ready && out_valid || !out_ready) begin
				gap = sink_quiet ? 0 : $urandom_range(0, 8);
				if (gap == 0 || $urandom_range(0, 3) == 0)
					out_ready <= 1;
				else begin
					out_ready <= 0;
					hold_left = gap - 1;
				end
			end
		end
	end

	// one quaternion transfer with a random idle gap ahead of it
	// valid stays high after a transfer so back to back items need no second drive
	task send_quaternion(logic [15:0] x, y, z, w, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		qx <= x;
		qy <= y;
		qz <= z;
		qw <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_quaternion(x, y, z, w);
	endtask

	task write_threshold(logic [14:0] v);
		cfg_valid <= 1;
		pole_threshold <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.thresh = v;
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// wait until every prediction has been matched, then let the pipe settle
	task drain_pipe();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// random near-unit quaternion from uniform random components, scaled to Q1.15
	task unit_quaternion(output logic [15:0] x, y, z, w);
		real a, b, c, n, v[4];
		for (int i = 0; i < 4; i++)
			v[i] = $itor($urandom_range(0, 65535)) - 32768.0;
		// sometimes push toward the poles, where x*y+z*w is near plus or minus one half
		if ($urandom_range(0, 3) == 0) begin
			v[1] = v[0] * ($urandom_range(0, 1) ? 1.0 : -1.0);
			v[3] = v[2] * ($urandom_range(0, 1) ? 1.0 : -1.0);
			v[1] = v[1] + ($itor($urandom_range(0, 400)) - 200.0);
		end
		n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]);
		if (n < 1.0)
			n = 1.0;
		a = 32767.0 / n;
		b = v[0] * a;
		c = v[1] * a;
		x = 16'($rtoi(b));
		y = 16'($rtoi(c));
		z = 16'($rtoi(v[2] * a));
		w = 16'($rtoi(v[3] * a));
	endtask

	initial begin
		logic [15:0] x, y, z, w;
		logic [14:0] th [5];
		th = '{15'd0, 15'd16384, 15'h7fff, 15'd8000, THRESH_RESET};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: identity, poles, extremes, zero operands, non-unit saturation
		send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h7fff, 0);
		send_quaternion(16'h5a82, 16'h5a82, 16'h0000, 16'h0000, 0);
		send_quaternion(16'h5a82, 16'ha57e, 16'h0000, 16'h0000, 0);
		send_quaternion(16'h0000, 16'h0000, 16'h5a82, 16'h5a82, 0);
		send_quaternion(16'h0000, 16'h0000, 16'h5a82, 16'ha57e, 0);
		send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
		send_quaternion(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
		send_quaternion(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
		send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h8000, 0);
		send_quaternion(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 0);
		send_quaternion(16'h0000, 16'h7fff, 16'h0000, 16'h0000, 0);
		send_quaternion(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 0);
		send_quaternion(16'h4000, 16'h4000, 16'h4000, 16'h4000, 0);
		send_quaternion(16'hc000, 16'h4000, 16'hc000, 16'h4000, 0);
		send_quaternion(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0);
		drain_pipe();

		// random phases across thresholds including zero and the extremes
		foreach (th[k]) begin
			write_threshold(th[k]);
			for (int i = 0; i < N_RANDOM / 5; i++) begin
				if ($urandom_range(0, 9) < 8)
					unit_quaternion(x, y, z, w);
				else begin
					x = 16'($urandom);
					y = 16'($urandom);
					z = 16'($urandom);
					w = 16'($urandom);
				end
				// hold the receiver off while the sender keeps streaming
				if (k == 1 && i == 10) begin
					hold_left = 3 * LATENCY;
					sink_quiet = 1;
				end
				if (k == 1 && i == 150)
					sink_quiet = 0;
				send_quaternion(x, y, z, w, (k == 1 && i < 150) || $urandom_range(0, 4) == 0);
			end
			drain_pipe();
		end

		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
